[sv/bidsc_pkg.sv]
// Shared types and codes for the backlight idle/dim/sleep controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bidsc_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL_BRIGHTNESS = 3'd0,
    CFG_DIM_LEVEL       = 3'd1,
    CFG_DIM_AFTER_MS    = 3'd2,
    CFG_SLEEP_AFTER_MS  = 3'd3,
    CFG_HOT_THRESHOLD   = 3'd4,
    CFG_STALE_AFTER_MS  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_AWAKE  = 2'd0,
    MODE_DIMMED = 2'd1,
    MODE_OFF    = 2'd2
  } mode_e;

  localparam logic [1:0] STATUS_OTHER    = 2'd0;
  localparam logic [1:0] STATUS_PRINTING = 2'd1;
  localparam logic [1:0] STATUS_SHUTDOWN = 2'd2;

  localparam logic [7:0]         RST_FULL_BRIGHTNESS = 8'd255;
  localparam logic [7:0]         RST_DIM_LEVEL       = 8'd32;
  localparam logic [31:0]        RST_DIM_AFTER_MS    = 32'd60000;
  localparam logic [31:0]        RST_SLEEP_AFTER_MS  = 32'd300000;
  localparam logic signed [10:0] RST_HOT_THRESHOLD   = 11'sd50;
  localparam logic [31:0]        RST_STALE_AFTER_MS  = 32'd10000;

  typedef struct packed {
    logic [7:0]         full_brightness;
    logic [7:0]         dim_level;
    logic [31:0]        dim_after_ms;
    logic [31:0]        sleep_after_ms;
    logic signed [10:0] hot_threshold;
    logic [31:0]        stale_after_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               touched;
    logic [31:0]        host_age_ms;
    logic               report_valid;
    logic signed [10:0] nozzle_temp;
    logic [1:0]         printer_status;
    logic               tool_used;
  } item_t;

  typedef struct packed {
    logic       backlight_write;
    logic [7:0] backlight_level;
    mode_e      display_mode;
    logic       link_stale;
  } res_t;

endpackage

`default_nettype wire

[sv/bidsc_cfg_regs.sv]
// Configuration register file of the backlight controller.
// Depends on bidsc_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module bidsc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [bidsc_pkg::CfgIdxW-1:0]   wr_index_i,
  input  logic [31:0]                     wr_data_i,
  output bidsc_pkg::cfg_t                 cfg_o
);

  bidsc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        bidsc_pkg::CFG_FULL_BRIGHTNESS: cfg_d.full_brightness = wr_data_i[7:0];
        bidsc_pkg::CFG_DIM_LEVEL:       cfg_d.dim_level       = wr_data_i[7:0];
        bidsc_pkg::CFG_DIM_AFTER_MS:    cfg_d.dim_after_ms    = wr_data_i;
        bidsc_pkg::CFG_SLEEP_AFTER_MS:  cfg_d.sleep_after_ms  = wr_data_i;
        bidsc_pkg::CFG_HOT_THRESHOLD:   cfg_d.hot_threshold   = $signed(wr_data_i[10:0]);
        bidsc_pkg::CFG_STALE_AFTER_MS:  cfg_d.stale_after_ms  = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_brightness <= bidsc_pkg::RST_FULL_BRIGHTNESS;
      cfg_q.dim_level       <= bidsc_pkg::RST_DIM_LEVEL;
      cfg_q.dim_after_ms    <= bidsc_pkg::RST_DIM_AFTER_MS;
      cfg_q.sleep_after_ms  <= bidsc_pkg::RST_SLEEP_AFTER_MS;
      cfg_q.hot_threshold   <= bidsc_pkg::RST_HOT_THRESHOLD;
      cfg_q.stale_after_ms  <= bidsc_pkg::RST_STALE_AFTER_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/bidsc_step.sv]
// Per-tick decision logic and controller state (modes, activity time, held report).
// Depends on bidsc_pkg for cfg_t, item_t, res_t and the mode and status codes.
`timescale 1ns / 1ps
`default_nettype none

module bidsc_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bidsc_pkg::cfg_t     cfg_i,
  input  bidsc_pkg::item_t    item_i,
  output bidsc_pkg::res_t     res_o
);

  logic               sleep_q, sleep_d;
  logic               dim_q, dim_d;
  logic [31:0]        last_act_q, last_act_d;
  logic signed [10:0] held_temp_q, held_temp_d;
  logic [1:0]         held_status_q, held_status_d;
  logic               held_used_q, held_used_d;

  logic        wrote, hot, in_job, alarm, stale, keep;
  logic [7:0]  level;
  logic [31:0] elapsed;

  always_comb begin
    sleep_d       = sleep_q;
    dim_d         = dim_q;
    last_act_d    = last_act_q;
    held_temp_d   = held_temp_q;
    held_status_d = held_status_q;
    held_used_d   = held_used_q;
    wrote         = 1'b0;
    level         = 8'd0;

    if (item_i.touched) begin
      last_act_d = item_i.now_ms;
      if (sleep_q || dim_q) begin
        wrote   = 1'b1;
        level   = cfg_i.full_brightness;
        sleep_d = 1'b0;
        dim_d   = 1'b0;
      end
    end

    hot    = held_temp_q > cfg_i.hot_threshold;
    in_job = (held_status_q == bidsc_pkg::STATUS_PRINTING) && held_used_q;
    alarm  = held_status_q == bidsc_pkg::STATUS_SHUTDOWN;
    stale  = item_i.host_age_ms > cfg_i.stale_after_ms;
    keep   = !stale && (hot || in_job || alarm);

    if ((sleep_d || dim_d) && keep) begin
      wrote      = 1'b1;
      level      = cfg_i.full_brightness;
      sleep_d    = 1'b0;
      dim_d      = 1'b0;
      last_act_d = item_i.now_ms;
    end

    elapsed = item_i.now_ms - last_act_d;

    if (!sleep_d && !dim_d && !keep && (elapsed > cfg_i.dim_after_ms)) begin
      wrote = 1'b1;
      level = cfg_i.dim_level;
      dim_d = 1'b1;
    end
    if (!sleep_d && !keep && (elapsed > cfg_i.sleep_after_ms)) begin
      wrote   = 1'b1;
      level   = 8'd0;
      sleep_d = 1'b1;
      dim_d   = 1'b0;
    end

    if (item_i.report_valid) begin
      held_temp_d   = item_i.nozzle_temp;
      held_status_d = item_i.printer_status;
      held_used_d   = item_i.tool_used;
    end

    res_o.backlight_write = wrote;
    res_o.backlight_level = wrote ? level : 8'd0;
    res_o.link_stale      = stale;
    priority if (sleep_d) begin
      res_o.display_mode = bidsc_pkg::MODE_OFF;
    end else if (dim_d) begin
      res_o.display_mode = bidsc_pkg::MODE_DIMMED;
    end else begin
      res_o.display_mode = bidsc_pkg::MODE_AWAKE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_q       <= 1'b0;
      dim_q         <= 1'b0;
      last_act_q    <= 32'd0;
      held_temp_q   <= 11'sd0;
      held_status_q <= bidsc_pkg::STATUS_OTHER;
      held_used_q   <= 1'b1;
    end else if (en_i) begin
      sleep_q       <= sleep_d;
      dim_q         <= dim_d;
      last_act_q    <= last_act_d;
      held_temp_q   <= held_temp_d;
      held_status_q <= held_status_d;
      held_used_q   <= held_used_d;
    end
  end

  a_modes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sleep_q && dim_q))
    else $error("sleeping and dimmed both set");

  a_dim_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.backlight_write && res_o.display_mode == bidsc_pkg::MODE_DIMMED)
    |-> (res_o.backlight_level == cfg_i.dim_level))
    else $error("dimmed with a level other than the dim level");

  a_off_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && res_o.backlight_write && res_o.display_mode == bidsc_pkg::MODE_OFF)
    |-> (res_o.backlight_level == 8'd0))
    else $error("off with a nonzero level");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(sleep_q) && $stable(dim_q) && $stable(last_act_q)))
    else $error("state changed without a tick");

endmodule

`default_nettype wire

[sv/backlight_idle_dim_sleep_controller_top.sv]
// Backlight idle/dim/sleep controller, top level.
// Holds the input and result registers; uses bidsc_pkg, bidsc_cfg_regs, bidsc_step.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one tick word: time, touch
//   flag, link age and an optional printer report. Output channel
//   (out_valid_o / out_stall_i) returns one result word per tick: backlight
//   write flag and level, display mode after the tick, and the stale flag.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes register
//   cfg_index_i with cfg_data_i; ready is always high. Unknown indexes are
//   dropped. Write only while no tick is in flight.
//   A tick accepted into the input register moves on to the result register.
//   Throughput: one tick per cycle while the result is not stalled; the
//   decision is a single combinational pass between the input and result registers.
//   Reset: all configuration registers take their defaults, the display is
//   awake, last activity time is 0, the held report is cool, status other,
//   tool used. Both channels come up empty.
//   Stall: while the result is stalled it holds; the input register keeps
//   one more tick and in_stall_o rises only when both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module backlight_idle_dim_sleep_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   now_ms_i,
  input  logic                          touched_i,
  input  logic [31:0]                   host_age_ms_i,
  input  logic                          report_valid_i,
  input  logic signed [10:0]            nozzle_temp_i,
  input  logic [1:0]                    printer_status_i,
  input  logic                          tool_used_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          backlight_write_o,
  output logic [7:0]                    backlight_level_o,
  output logic [1:0]                    display_mode_o,
  output logic                          link_stale_o,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bidsc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  bidsc_pkg::cfg_t  cfg;
  bidsc_pkg::item_t item_q;
  bidsc_pkg::res_t  res, res_q;
  logic             in_vld_q, out_vld_q;
  logic             out_free, advance, in_take;

  assign cfg_ready_o = 1'b1;

  bidsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  bidsc_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .cfg_i  (cfg),
    .item_i (item_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.now_ms         <= now_ms_i;
      item_q.touched        <= touched_i;
      item_q.host_age_ms    <= host_age_ms_i;
      item_q.report_valid   <= report_valid_i;
      item_q.nozzle_temp    <= nozzle_temp_i;
      item_q.printer_status <= printer_status_i;
      item_q.tool_used      <= tool_used_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign backlight_write_o = res_q.backlight_write;
  assign backlight_level_o = res_q.backlight_level;
  assign display_mode_o    = res_q.display_mode;
  assign link_stale_o      = res_q.link_stale;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("result register empty after a tick moved");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> in_vld_q)
    else $error("pending tick lost");

  a_quiet_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_q.backlight_write) |-> (res_q.backlight_level == 8'd0))
    else $error("level nonzero without a write");

endmodule

`default_nettype wire

[bench/tb_backlight_idle_dim_sleep_controller_top.sv]
// Self-checking bench for backlight_idle_dim_sleep_controller_top: a directed table,
// then random ticks over several register settings, with random stalls on both sides.
// Depends on bidsc_pkg and the controller RTL only.
`timescale 1ns / 1ps

module tb_backlight_idle_dim_sleep_controller_top;

  localparam logic [bidsc_pkg::CfgIdxW-1:0] CFG_IDX_SPARE6 = 3'd6;
  localparam logic [bidsc_pkg::CfgIdxW-1:0] CFG_IDX_SPARE7 = 3'd7;
  localparam logic [1:0]         STATUS_CODE3   = 2'd3;
  localparam int unsigned        PHASES         = 6;
  localparam int unsigned        TICKS_PER_PHASE = 100;
  localparam int unsigned        LONG_HOLD      = 200;
  localparam int unsigned        STEP_SPAN      = 800;
  localparam int unsigned        DIR_ROWS       = 16;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [31:0]          now_ms_i;
  logic                 touched_i;
  logic [31:0]          host_age_ms_i;
  logic                 report_valid_i;
  logic signed [10:0]   nozzle_temp_i;
  logic [1:0]           printer_status_i;
  logic                 tool_used_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 backlight_write_o;
  logic [7:0]           backlight_level_o;
  logic [1:0]           display_mode_o;
  logic                 link_stale_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [bidsc_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  backlight_idle_dim_sleep_controller_top dut (.*);

  typedef struct {
    bidsc_pkg::item_t tick;
    bit               typed;
    bidsc_pkg::res_t  want;
  } dir_row_t;

  // shadow copy of the controller
  bidsc_pkg::cfg_t    shadow_cfg;
  bit                 shadow_sleeping;
  bit                 shadow_dimmed;
  logic [31:0]        shadow_last_act;
  logic signed [10:0] shadow_temp;
  logic [1:0]         shadow_status;
  bit                 shadow_used;

  bidsc_pkg::res_t pending_results[$];
  bidsc_pkg::res_t oldest;
  dir_row_t    dir_rows[DIR_ROWS];
  logic [31:0] tick_ms;
  bit          quiet;
  bit          hold_req;
  int unsigned fault_cnt;
  int unsigned results_seen;
  int unsigned writes_seen;
  int unsigned ticks_sent;

  function automatic bidsc_pkg::res_t predict_backlight(input bidsc_pkg::item_t t);
    bidsc_pkg::res_t r;
    bit          hot, in_job, alarm, stale, keep;
    logic [31:0] idle;
    r = '0;
    if (t.touched) begin
      shadow_last_act = t.now_ms;
      if (shadow_sleeping || shadow_dimmed) begin
        r.backlight_write = 1'b1;
        r.backlight_level = shadow_cfg.full_brightness;
        shadow_sleeping   = 1'b0;
        shadow_dimmed     = 1'b0;
      end
    end
    hot    = $signed(shadow_temp) > $signed(shadow_cfg.hot_threshold);
    in_job = (shadow_status == bidsc_pkg::STATUS_PRINTING) && shadow_used;
    alarm  = shadow_status == bidsc_pkg::STATUS_SHUTDOWN;
    stale  = t.host_age_ms > shadow_cfg.stale_after_ms;
    keep   = !stale && (hot || in_job || alarm);
    if ((shadow_sleeping || shadow_dimmed) && keep) begin
      r.backlight_write = 1'b1;
      r.backlight_level = shadow_cfg.full_brightness;
      shadow_sleeping   = 1'b0;
      shadow_dimmed     = 1'b0;
      shadow_last_act   = t.now_ms;
    end
    idle = t.now_ms - shadow_last_act;
    if (!shadow_sleeping && !shadow_dimmed && !keep && idle > shadow_cfg.dim_after_ms) begin
      r.backlight_write = 1'b1;
      r.backlight_level = shadow_cfg.dim_level;
      shadow_dimmed     = 1'b1;
    end
    if (!shadow_sleeping && !keep && idle > shadow_cfg.sleep_after_ms) begin
      r.backlight_write = 1'b1;
      r.backlight_level = 8'd0;
      shadow_sleeping   = 1'b1;
      shadow_dimmed     = 1'b0;
    end
    if (t.report_valid) begin
      shadow_temp   = t.nozzle_temp;
      shadow_status = t.printer_status;
      shadow_used   = t.tool_used;
    end
    if (shadow_sleeping) begin
      r.display_mode = bidsc_pkg::MODE_OFF;
    end else if (shadow_dimmed) begin
      r.display_mode = bidsc_pkg::MODE_DIMMED;
    end else begin
      r.display_mode = bidsc_pkg::MODE_AWAKE;
    end
    r.link_stale   = stale;
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic [31:0] now, input bit touch,
                                      input logic [31:0] age, input bit rep,
                                      input logic signed [10:0] temp, input logic [1:0] status,
                                      input bit used, input bit typed, input bit wr,
                                      input logic [7:0] lvl, input bidsc_pkg::mode_e mode,
                                      input bit stale);
    dir_row_t row;
    row.tick.now_ms               = now;
    row.tick.touched              = touch;
    row.tick.host_age_ms          = age;
    row.tick.report_valid         = rep;
    row.tick.nozzle_temp          = temp;
    row.tick.printer_status       = status;
    row.tick.tool_used            = used;
    row.typed                     = typed;
    row.want.backlight_write      = wr;
    row.want.backlight_level      = lvl;
    row.want.display_mode         = mode;
    row.want.link_stale           = stale;
    return row;
  endfunction

  function automatic bidsc_pkg::item_t random_tick();
    bidsc_pkg::item_t t;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)      tick_ms = tick_ms + $urandom_range(0, STEP_SPAN);
    else if (pick < 90) tick_ms = tick_ms + $urandom_range(0, 4 * STEP_SPAN);
    else if (pick < 97) tick_ms = $urandom;
    else                tick_ms = 32'hFFFF_FFFF - $urandom_range(0, STEP_SPAN);
    t.now_ms  = tick_ms;
    t.touched = ($urandom_range(0, 7) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 55)      t.host_age_ms = $urandom_range(0, 10000);
    else if (pick < 65) t.host_age_ms = shadow_cfg.stale_after_ms + $urandom_range(0, 1);
    else if (pick < 80) t.host_age_ms = $urandom;
    else if (pick < 85) t.host_age_ms = 32'hFFFF_FFFF;
    else                t.host_age_ms = 32'd0;
    t.report_valid = ($urandom_range(0, 2) == 0);
    if ($urandom_range(0, 1) == 0)
      t.nozzle_temp = shadow_cfg.hot_threshold + 11'($urandom_range(0, 4)) - 11'sd2;
    else
      t.nozzle_temp = 11'($urandom);
    t.printer_status = 2'($urandom_range(0, 3));
    t.tool_used      = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic send_tick(input bidsc_pkg::item_t t, input bit typed,
                           input bidsc_pkg::res_t want);
    bidsc_pkg::res_t predicted;
    in_valid_i       <= 1'b1;
    now_ms_i         <= t.now_ms;
    touched_i        <= t.touched;
    host_age_ms_i    <= t.host_age_ms;
    report_valid_i   <= t.report_valid;
    nozzle_temp_i    <= t.nozzle_temp;
    printer_status_i <= t.printer_status;
    tool_used_i      <= t.tool_used;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_backlight(t);
    pending_results.push_back(typed ? want : predicted);
    ticks_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(input logic [bidsc_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bidsc_pkg::CFG_FULL_BRIGHTNESS: shadow_cfg.full_brightness = data[7:0];
      bidsc_pkg::CFG_DIM_LEVEL:       shadow_cfg.dim_level       = data[7:0];
      bidsc_pkg::CFG_DIM_AFTER_MS:    shadow_cfg.dim_after_ms    = data;
      bidsc_pkg::CFG_SLEEP_AFTER_MS:  shadow_cfg.sleep_after_ms  = data;
      bidsc_pkg::CFG_HOT_THRESHOLD:   shadow_cfg.hot_threshold   = data[10:0];
      bidsc_pkg::CFG_STALE_AFTER_MS:  shadow_cfg.stale_after_ms  = data;
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_phase(input int unsigned ph);
    logic [7:0]         full, dim;
    logic [31:0]        dim_after, sleep_after, stale;
    logic signed [10:0] hot;
    case (ph)
      0: begin
        full = 8'd255; dim = 8'd0; dim_after = 32'd0; sleep_after = 32'd0;
        hot = 11'h400; stale = 32'd0;
      end
      1: begin
        full = 8'd0; dim = 8'd255; dim_after = 32'hFFFF_FFFF; sleep_after = 32'hFFFF_FFFF;
        hot = 11'h3FF; stale = 32'hFFFF_FFFF;
      end
      default: begin
        full        = 8'($urandom);
        dim         = 8'($urandom);
        dim_after   = $urandom_range(0, 3000);
        sleep_after = $urandom_range(0, 6000);
        hot         = 11'($urandom);
        stale       = $urandom_range(0, 5000);
      end
    endcase
    cfg_write(bidsc_pkg::CFG_FULL_BRIGHTNESS, {24'd0, full});
    cfg_write(bidsc_pkg::CFG_DIM_LEVEL, {24'd0, dim});
    cfg_write(bidsc_pkg::CFG_DIM_AFTER_MS, dim_after);
    cfg_write(bidsc_pkg::CFG_SLEEP_AFTER_MS, sleep_after);
    cfg_write(bidsc_pkg::CFG_HOT_THRESHOLD, {{21{hot[10]}}, hot});
    cfg_write(bidsc_pkg::CFG_STALE_AFTER_MS, stale);
    // out-of-range index, must be dropped
    cfg_write(ph[0] ? CFG_IDX_SPARE7 : CFG_IDX_SPARE6, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("tb_backlight_idle_dim_sleep_controller_top: FAIL");
    $finish;
  end

  initial begin : receiver
    bit          hold;
    int unsigned span;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = 1'b1;
        span     = LONG_HOLD;
      end else if (quiet) begin
        hold = 1'b0;
        span = 1;
      end else begin
        hold = ($urandom_range(0, 2) == 0);
        span = $urandom_range(1, 10);
      end
      out_stall_i <= hold;
      repeat (span) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (backlight_write_o) writes_seen++;
      if (pending_results.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("%0t: result word with nothing expected (write %0d level %0d mode %0d)",
                   $time, backlight_write_o, backlight_level_o, display_mode_o);
      end else begin
        oldest = pending_results.pop_front();
        if (backlight_write_o !== oldest.backlight_write ||
            backlight_level_o !== oldest.backlight_level ||
            display_mode_o    !== oldest.display_mode    ||
            link_stale_o      !== oldest.link_stale) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display("%0t: mismatch write %0d/%0d level %0d/%0d mode %0d/%0d stale %0d/%0d %s",
                     $time, oldest.backlight_write, backlight_write_o,
                     oldest.backlight_level, backlight_level_o,
                     oldest.display_mode, display_mode_o,
                     oldest.link_stale, link_stale_o, "(expected/actual)");
        end
      end
    end
  end

  initial begin : sender
    bidsc_pkg::item_t t;
    bidsc_pkg::res_t  none;
    none             = '0;
    quiet            = 1'b0;
    hold_req         = 1'b0;
    fault_cnt        = 0;
    results_seen     = 0;
    writes_seen      = 0;
    ticks_sent       = 0;
    tick_ms          = $urandom;
    shadow_cfg.full_brightness = bidsc_pkg::RST_FULL_BRIGHTNESS;
    shadow_cfg.dim_level       = bidsc_pkg::RST_DIM_LEVEL;
    shadow_cfg.dim_after_ms    = bidsc_pkg::RST_DIM_AFTER_MS;
    shadow_cfg.sleep_after_ms  = bidsc_pkg::RST_SLEEP_AFTER_MS;
    shadow_cfg.hot_threshold   = bidsc_pkg::RST_HOT_THRESHOLD;
    shadow_cfg.stale_after_ms  = bidsc_pkg::RST_STALE_AFTER_MS;
    shadow_sleeping  = 1'b0;
    shadow_dimmed    = 1'b0;
    shadow_last_act  = 32'd0;
    shadow_temp      = 11'sd0;
    shadow_status    = bidsc_pkg::STATUS_OTHER;
    shadow_used      = 1'b1;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    now_ms_i         <= 32'd0;
    touched_i        <= 1'b0;
    host_age_ms_i    <= 32'd0;
    report_valid_i   <= 1'b0;
    nozzle_temp_i    <= 11'sd0;
    printer_status_i <= bidsc_pkg::STATUS_OTHER;
    tool_used_i      <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= bidsc_pkg::CFG_FULL_BRIGHTNESS;
    cfg_data_i       <= 32'd0;

    // now, touch, age, report, temp, status, used | typed, write, level, mode, stale
    dir_rows[0]  = mk_row(32'd0, 0, 32'd0, 0, 11'sd0, bidsc_pkg::STATUS_OTHER, 0,
                          1, 0, 8'd0, bidsc_pkg::MODE_AWAKE, 0);
    dir_rows[1]  = mk_row(32'd60000, 0, 32'd10000, 0, 11'sd0, bidsc_pkg::STATUS_OTHER, 0,
                          1, 0, 8'd0, bidsc_pkg::MODE_AWAKE, 0);
    dir_rows[2]  = mk_row(32'd60001, 0, 32'd10001, 0, 11'sd0, bidsc_pkg::STATUS_OTHER, 0,
                          1, 1, 8'd32, bidsc_pkg::MODE_DIMMED, 1);
    dir_rows[3]  = mk_row(32'd300001, 0, 32'd0, 0, 11'sd0, bidsc_pkg::STATUS_OTHER, 0,
                          1, 1, 8'd0, bidsc_pkg::MODE_OFF, 0);
    dir_rows[4]  = mk_row(32'd300002, 1, 32'hFFFF_FFFF, 1, 11'h3FF, bidsc_pkg::STATUS_OTHER, 0,
                          1, 1, 8'd255, bidsc_pkg::MODE_AWAKE, 1);
    dir_rows[5]  = mk_row(32'd700002, 0, 32'd0, 1, 11'h400, bidsc_pkg::STATUS_SHUTDOWN, 0,
                          1, 0, 8'd0, bidsc_pkg::MODE_AWAKE, 0);
    // stale link overrides the alarm; dim and sleep land in one tick
    dir_rows[6]  = mk_row(32'd700003, 0, 32'd20000, 1, 11'h400, bidsc_pkg::STATUS_PRINTING, 1,
                          1, 1, 8'd0, bidsc_pkg::MODE_OFF, 1);
    dir_rows[7]  = mk_row(32'd700004, 0, 32'd0, 1, 11'sd50, STATUS_CODE3, 1,
                          0, 0, 8'd0, bidsc_pkg::MODE_AWAKE, 0);
    dir_rows[8]  = mk_row(32'd760005, 0, 32'd0, 1, 11'sd51, bidsc_pkg::STATUS_OTHER, 1,
                          0, 0, 8'd0, bidsc_pkg::MODE_AWAKE, 0);
    dir_rows[9]  = mk_row(32'd760006, 0, 32'd0, 1, 11'sd0, bidsc_pkg::STATUS_PRINTING, 0,
                          0, 0, 8'd0, bidsc_pkg::MODE_AWAKE, 0);
    dir_rows[10] = mk_row(32'd1060007, 0, 32'd0, 0, 11'h3FF, bidsc_pkg::STATUS_SHUTDOWN, 1,
                          1, 1, 8'd0, bidsc_pkg::MODE_OFF, 0);
    dir_rows[11] = mk_row(32'd1060008, 0, 32'd0, 0, 11'sd0, bidsc_pkg::STATUS_OTHER, 0,
                          1, 0, 8'd0, bidsc_pkg::MODE_OFF, 0);
    dir_rows[12] = mk_row(32'hFFFF_FFF0, 1, 32'd0, 0, 11'sd0, bidsc_pkg::STATUS_OTHER, 0,
                          1, 1, 8'd255, bidsc_pkg::MODE_AWAKE, 0);
    // idle time across the wrap
    dir_rows[13] = mk_row(32'd60000, 0, 32'd0, 0, 11'sd0, bidsc_pkg::STATUS_OTHER, 0,
                          1, 1, 8'd32, bidsc_pkg::MODE_DIMMED, 0);
    dir_rows[14] = mk_row(32'h0001_0000, 1, 32'd0, 0, 11'sd0, bidsc_pkg::STATUS_OTHER, 0,
                          0, 0, 8'd0, bidsc_pkg::MODE_AWAKE, 0);
    dir_rows[15] = mk_row(32'h0001_0001, 1, 32'd0, 0, 11'sd0, bidsc_pkg::STATUS_OTHER, 0,
                          1, 0, 8'd0, bidsc_pkg::MODE_AWAKE, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain();
      program_phase(ph);
      if (ph == 2) hold_req = 1'b1;
      if (ph == PHASES - 1) quiet = 1'b1;
      for (int unsigned n = 0; n < TICKS_PER_PHASE; n++) begin
        t = random_tick();
        send_tick(t, 1'b0, none);
      end
    end

    drain();
    $display("%0d ticks sent over %0d register settings, %0d result words checked",
             ticks_sent, PHASES + 1, results_seen);
    $display("%0d backlight writes seen, %0d mismatches", writes_seen, fault_cnt);
    if (fault_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_backlight_idle_dim_sleep_controller_top: PASS");
    end else begin
      $display("tb_backlight_idle_dim_sleep_controller_top: FAIL");
    end
    $finish;
  end

endmodule
